// ===== src/q24alu_pkg.sv =====
// Package with opcodes, constants and the stage record of the Q24.8 ALU.
`timescale 1ns / 1ps
package q24alu_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    typedef struct packed {
        logic        vld;
        logic        neg;
        logic        dz;
        logic        is_div;
        logic [31:0] direct;
    } ctl_t;

endpackage

// ===== src/q24alu_cell.sv =====
// One cell of the divider chain: one restoring step on the running remainder.
`timescale 1ns / 1ps
module q24alu_cell #(
    parameter int NUM_W = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  q24alu_pkg::ctl_t     ctl_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [32:0]          rem_in,
    input  logic [31:0]          den_in,
    input  logic [NUM_W-1:0]     quo_in,
    output q24alu_pkg::ctl_t     ctl_out,
    output logic [NUM_W-1:0]     num_out,
    output logic [32:0]          rem_out,
    output logic [31:0]          den_out,
    output logic [NUM_W-1:0]     quo_out
);
    logic [33:0]      trial;
    logic [33:0]      shifted;
    logic [32:0]      rem_next;
    logic [NUM_W-1:0] quo_next;
    logic [NUM_W-1:0] num_next;
    logic             vld_reg;
    q24alu_pkg::ctl_t ctl_reg;
    logic [NUM_W-1:0] num_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      den_reg;
    logic [NUM_W-1:0] quo_reg;

    always_comb
    begin
        shifted  = {rem_in, num_in[NUM_W-1]};
        trial    = shifted - {2'b00, den_in};
        num_next = {num_in[NUM_W-2:0], 1'b0};
        if (!trial[33])
        begin
            rem_next = trial[32:0];
            quo_next = {quo_in[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[32:0];
            quo_next = {quo_in[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            ctl_reg <= ctl_in;
            num_reg <= num_next;
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        ctl_out     = ctl_reg;
        ctl_out.vld = vld_reg;
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
endmodule

// ===== src/q24_8_fixed_point_alu.sv =====
// Top level of the signed Q24.8 fixed-point ALU with a pipelined divider chain.
// Stages: one operand stage, FRACTION_BITS + 32 divider cells with the product formed
// ahead of the first cell, one rounding stage and one output register.
// Throughput: one transaction per cycle; the whole pipeline advances when not stalled.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module q24_8_fixed_point_alu #(
    parameter int FRACTION_BITS = q24alu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic               compare_true,
    output logic               divide_by_zero
);
    localparam int NUM_W = 32 + FRACTION_BITS;
    localparam int NCELL = NUM_W;

    logic enable;

    // Stage 0: operand decode.
    q24alu_pkg::ctl_t  s0_ctl;
    logic [NUM_W-1:0]  s0_num;
    logic [31:0]       s0_den;
    logic [31:0]       mag_a;
    logic [31:0]       mag_b;
    logic              lt_ab;
    logic [31:0]       toint_m;
    logic              cmp_bit;
    logic [31:0]       direct_v;
    logic              is_cmp;
    logic              is_mul;
    q24alu_pkg::op_t   op;

    always_comb
    begin
        op      = q24alu_pkg::op_t'(opcode);
        mag_a   = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        mag_b   = operand_b[31] ? (32'd0 - operand_b) : operand_b;
        lt_ab   = operand_a < operand_b;
        toint_m = mag_a >> FRACTION_BITS;
        cmp_bit = 1'b0;
        is_cmp  = 1'b0;
        direct_v = 32'd0;
        case (op)
            q24alu_pkg::OP_ADD:     direct_v = operand_a + operand_b;
            q24alu_pkg::OP_SUB:     direct_v = operand_a - operand_b;
            q24alu_pkg::OP_GT:      begin is_cmp = 1'b1; cmp_bit = operand_b < operand_a; end
            q24alu_pkg::OP_LT:      begin is_cmp = 1'b1; cmp_bit = lt_ab; end
            q24alu_pkg::OP_GE:      begin is_cmp = 1'b1; cmp_bit = !lt_ab; end
            q24alu_pkg::OP_LE:      begin is_cmp = 1'b1; cmp_bit = !(operand_b < operand_a); end
            q24alu_pkg::OP_EQ:      begin is_cmp = 1'b1; cmp_bit = operand_a == operand_b; end
            q24alu_pkg::OP_NE:      begin is_cmp = 1'b1; cmp_bit = operand_a != operand_b; end
            q24alu_pkg::OP_MIN:     direct_v = (operand_b < operand_a) ? operand_b : operand_a;
            q24alu_pkg::OP_MAX:     direct_v = (operand_b < operand_a) ? operand_a : operand_b;
            q24alu_pkg::OP_INC:     direct_v = operand_a + 32'd1;
            q24alu_pkg::OP_DEC:     direct_v = operand_a - 32'd1;
            q24alu_pkg::OP_TOINT:   direct_v = operand_a[31] ? (32'd0 - toint_m) : toint_m;
            q24alu_pkg::OP_FROMINT: direct_v = operand_a << FRACTION_BITS;
            default:                direct_v = 32'd0;
        endcase
        is_mul = op == q24alu_pkg::OP_MUL;
    end

    logic              p_vld_reg;
    logic              p_cmp_reg;
    logic              p_mul_reg;
    logic              p_div_reg;
    logic              p_neg_reg;
    logic              p_dz_reg;
    logic              p_asgn_reg;
    logic              p_azero_reg;
    logic [31:0]       p_direct_reg;
    logic [31:0]       p_ma_reg;
    logic [31:0]       p_mb_reg;

    assign enable   = !out_valid || !out_stall;
    assign in_stall = !enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            p_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            p_cmp_reg    <= is_cmp & cmp_bit;
            p_mul_reg    <= is_mul;
            p_div_reg    <= op == q24alu_pkg::OP_DIV;
            p_neg_reg    <= operand_a[31] ^ operand_b[31];
            p_dz_reg     <= (op == q24alu_pkg::OP_DIV) && (operand_b == 32'sd0);
            p_asgn_reg   <= operand_a[31];
            p_azero_reg  <= operand_a == 32'sd0;
            p_direct_reg <= direct_v;
            p_ma_reg     <= mag_a;
            p_mb_reg     <= mag_b;
        end
    end

    // Stage 1: product and divider entry.
    logic [63:0]      prod;
    logic [63:0]      prod_rnd;
    logic [32:0]      mul_m;
    logic [31:0]      direct1;

    always_comb
    begin
        prod     = p_ma_reg * p_mb_reg;
        prod_rnd = prod + (64'd1 << (FRACTION_BITS - 1));
        mul_m    = (prod_rnd[63:FRACTION_BITS] > 64'h1_0000_0000 >> 0) ?
                   33'h1_0000_0001 : prod_rnd[FRACTION_BITS+32:FRACTION_BITS];
        direct1  = p_direct_reg;
        if (p_mul_reg)
        begin
            if (p_neg_reg)
                direct1 = (mul_m > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mul_m[31:0]);
            else
                direct1 = (mul_m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mul_m[31:0];
        end
        if (p_dz_reg)
            direct1 = p_azero_reg ? 32'd0 : (p_asgn_reg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        s0_ctl.vld    = p_vld_reg;
        s0_ctl.neg    = p_neg_reg;
        s0_ctl.dz     = p_dz_reg;
        s0_ctl.is_div = p_div_reg && !p_dz_reg;
        s0_ctl.direct = direct1;
        s0_num        = {p_ma_reg, {FRACTION_BITS{1'b0}}};
        s0_den        = p_mb_reg;
    end

    logic              cmp_pipe_reg [NCELL+1];
    q24alu_pkg::ctl_t  ctl_w [NCELL+1];
    logic [NUM_W-1:0]  num_w [NCELL+1];
    logic [32:0]       rem_w [NCELL+1];
    logic [31:0]       den_w [NCELL+1];
    logic [NUM_W-1:0]  quo_w [NCELL+1];

    assign ctl_w[0] = s0_ctl;
    assign num_w[0] = s0_num;
    assign rem_w[0] = 33'd0;
    assign den_w[0] = s0_den;
    assign quo_w[0] = '0;
    assign cmp_pipe_reg[0] = p_cmp_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        q24alu_cell #(.NUM_W(NUM_W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .enable  (enable),
            .ctl_in  (ctl_w[i]),
            .num_in  (num_w[i]),
            .rem_in  (rem_w[i]),
            .den_in  (den_w[i]),
            .quo_in  (quo_w[i]),
            .ctl_out (ctl_w[i+1]),
            .num_out (num_w[i+1]),
            .rem_out (rem_w[i+1]),
            .den_out (den_w[i+1]),
            .quo_out (quo_w[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                cmp_pipe_reg[i+1] <= cmp_pipe_reg[i];
            end
        end
    end

    // Rounding stage: round half away from zero, then saturate.
    logic              r_vld_reg;
    logic              r_neg_reg;
    logic              r_div_reg;
    logic              r_dz_reg;
    logic              r_cmp_reg;
    logic              r_up_reg;
    logic [31:0]       r_direct_reg;
    logic [NUM_W-1:0]  r_quo_reg;
    logic [NUM_W:0]    q_rnd;
    logic [31:0]       fin_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            r_vld_reg <= ctl_w[NCELL].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            r_neg_reg    <= ctl_w[NCELL].neg;
            r_div_reg    <= ctl_w[NCELL].is_div;
            r_dz_reg     <= ctl_w[NCELL].dz;
            r_cmp_reg    <= cmp_pipe_reg[NCELL];
            r_direct_reg <= ctl_w[NCELL].direct;
            r_quo_reg    <= quo_w[NCELL];
            r_up_reg     <= {rem_w[NCELL], 1'b0} >= {2'b00, den_w[NCELL]};
        end
    end

    always_comb
    begin
        q_rnd = {1'b0, r_quo_reg} + {{NUM_W{1'b0}}, r_up_reg};
        fin_v = r_direct_reg;
        if (r_div_reg)
        begin
            if (r_neg_reg)
                fin_v = (q_rnd > (NUM_W+1)'(33'h0_8000_0000)) ? 32'h8000_0000 :
                        (32'd0 - q_rnd[31:0]);
            else
                fin_v = (q_rnd > (NUM_W+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q_rnd[31:0];
        end
    end

    logic              o_vld_reg;
    logic [31:0]       o_val_reg;
    logic              o_cmp_reg;
    logic              o_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (enable)
        begin
            o_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            o_val_reg <= fin_v;
            o_cmp_reg <= r_cmp_reg;
            o_dz_reg  <= r_dz_reg;
        end
    end

    assign out_valid      = o_vld_reg;
    assign result_value   = o_val_reg;
    assign compare_true   = o_cmp_reg;
    assign divide_by_zero = o_dz_reg;
endmodule
